/* rtl/ws_pkg.sv */
package ws_pkg;

  localparam int NUM_LEDS      = 7;
  localparam int BYTES_PER_LED = 3;
  localparam int FRAME_BYTES   = NUM_LEDS * BYTES_PER_LED;
  localparam int POS_W         = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  localparam int TICK_W = 12;
  localparam int ADDR_W = 4;

  // Item operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ZERO_HIGH   = 2'd0;
  localparam logic [1:0] REG_ZERO_PERIOD = 2'd1;
  localparam logic [1:0] REG_ONE_HIGH    = 2'd2;
  localparam logic [1:0] REG_ONE_PERIOD  = 2'd3;

  localparam logic [TICK_W-1:0] ZERO_HIGH_RST   = TICK_W'(42);
  localparam logic [TICK_W-1:0] ZERO_PERIOD_RST = TICK_W'(143);
  localparam logic [TICK_W-1:0] ONE_HIGH_RST    = TICK_W'(168);
  localparam logic [TICK_W-1:0] ONE_PERIOD_RST  = TICK_W'(277);

  typedef struct packed {
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_period;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_period;
  } ws_cfg_t;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] base;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic [7:0]       byte2;
  } ws_wr_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [2:0]       bit_idx;
  } ws_rd_t;

endpackage

/* rtl/ws_frame_store.sv */
module ws_frame_store (
  input  logic          clk,
  input  logic          rst_n,
  input  ws_pkg::ws_wr_t wr,
  input  ws_pkg::ws_rd_t rd,
  output logic          rd_bit
);
  import ws_pkg::*;

  logic [7:0] store_r   [FRAME_BYTES];
  logic [7:0] store_nxt [FRAME_BYTES];

  // One LED write lands on three consecutive bytes: green, red, blue.
  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      store_nxt[i] = store_r[i];
      if (wr.en && (i == int'(wr.base))) begin
        store_nxt[i] = wr.byte0;
      end
      if (wr.en && (i == int'(wr.base) + 1)) begin
        store_nxt[i] = wr.byte1;
      end
      if (wr.en && (i == int'(wr.base) + 2)) begin
        store_nxt[i] = wr.byte2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_r[i] <= 8'd0;
      end
    end else begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

  assign rd_bit = store_r[rd.pos][rd.bit_idx];

endmodule

/* rtl/ws_bit_engine.sv */
module ws_bit_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_en,
  input  logic [1:0]      op,
  input  ws_pkg::ws_cfg_t cfg,
  input  logic            rd_bit,
  output ws_pkg::ws_rd_t  rd,
  output logic            line_nxt,
  output logic            busy_nxt
);
  import ws_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic              cur_r, cur_nxt;
  logic              sending_r, sending_nxt;

  logic              load_bit;
  logic [TICK_W-1:0] period;
  logic [TICK_W-1:0] high_nxt;
  logic [TICK_W:0]   tick_inc;

  assign period   = cur_r ? cfg.one_period : cfg.zero_period;
  assign tick_inc = {1'b0, tick_r} + 1'b1;

  // Position, timer and run state; the new bit is fetched at the new position.
  always_comb begin
    pos_nxt     = pos_r;
    bit_nxt     = bit_r;
    tick_nxt    = tick_r;
    sending_nxt = sending_r;
    load_bit    = 1'b0;
    if (item_en) begin
      case (op)
        OP_START: begin
          if (!sending_r) begin
            sending_nxt = 1'b1;
            pos_nxt     = '0;
            bit_nxt     = 3'd7;
            tick_nxt    = '0;
            load_bit    = 1'b1;
          end
        end
        OP_TICK: begin
          if (sending_r) begin
            if (tick_inc < {1'b0, period}) begin
              tick_nxt = tick_inc[TICK_W-1:0];
            end else begin
              tick_nxt = '0;
              load_bit = 1'b1;
              if (bit_r != 3'd0) begin
                bit_nxt = bit_r - 3'd1;
              end else if (pos_r != LAST_POS) begin
                bit_nxt = 3'd7;
                pos_nxt = pos_r + 1'b1;
              end else begin
                // Last bit of the frame is done: go idle.
                sending_nxt = 1'b0;
                bit_nxt     = 3'd7;
                pos_nxt     = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rd.pos     = pos_nxt;
  assign rd.bit_idx = bit_nxt;

  always_comb begin
    cur_nxt = cur_r;
    if (load_bit) begin
      cur_nxt = sending_nxt ? rd_bit : 1'b0;
    end
  end

  assign high_nxt = cur_nxt ? cfg.one_high : cfg.zero_high;
  assign line_nxt = sending_nxt && (tick_nxt < high_nxt);
  assign busy_nxt = sending_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      bit_r     <= 3'd7;
      tick_r    <= '0;
      cur_r     <= 1'b0;
      sending_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      bit_r     <= bit_nxt;
      tick_r    <= tick_nxt;
      cur_r     <= cur_nxt;
      sending_r <= sending_nxt;
    end
  end

endmodule

/* rtl/ws2812_bit_serializer_core.sv */
// Single-wire RGB LED chain serializer. Write items store one LED's color
// (sent green, red, blue), a start item begins sending the whole frame when
// idle, and each tick item advances the bit timer by one tick while sending; every item
// returns one result with the line level and the busy flag after it. The
// block takes one item per clock: an input register and a result register
// hold the item and its result, and all of an item's work is combinational
// logic between them, done as the item moves from the input register into
// the result register. A stalled result holds the input register, which then
// stalls the input. Bit timing comes from four 12-bit registers at byte
// addresses 0, 4, 8 and 12; write them only while no item is in flight. A
// new value takes effect at once, even in the middle of a bit.
module ws2812_bit_serializer_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_op,
  input  logic [2:0]                in_led,
  input  logic [7:0]                in_red,
  input  logic [7:0]                in_green,
  input  logic [7:0]                in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_line,
  output logic                      out_busy_res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ws_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ws_pkg::*;

  ws_cfg_t cfg_r;

  logic       s1_valid_r;
  logic [1:0] s1_op_r;
  logic [2:0] s1_led_r;
  logic [7:0] s1_red_r, s1_green_r, s1_blue_r;
  logic       advance;

  logic       out_valid_r;
  logic       out_line_r, out_busy_r;

  ws_wr_t wr;
  ws_rd_t rd;
  logic   rd_bit;
  logic   line_nxt, busy_nxt;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_high   <= ZERO_HIGH_RST;
      cfg_r.zero_period <= ZERO_PERIOD_RST;
      cfg_r.one_high    <= ONE_HIGH_RST;
      cfg_r.one_period  <= ONE_PERIOD_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ZERO_HIGH:   cfg_r.zero_high   <= pwdata[TICK_W-1:0];
        REG_ZERO_PERIOD: cfg_r.zero_period <= pwdata[TICK_W-1:0];
        REG_ONE_HIGH:    cfg_r.one_high    <= pwdata[TICK_W-1:0];
        REG_ONE_PERIOD:  cfg_r.one_period  <= pwdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ZERO_HIGH:   prdata = {20'd0, cfg_r.zero_high};
      REG_ZERO_PERIOD: prdata = {20'd0, cfg_r.zero_period};
      REG_ONE_HIGH:    prdata = {20'd0, cfg_r.one_high};
      REG_ONE_PERIOD:  prdata = {20'd0, cfg_r.one_period};
      default:         prdata = 32'd0;
    endcase
  end

  // Input register: the held item is processed when the result slot frees.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r    <= in_op;
      s1_led_r   <= in_led;
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
    end
  end

  assign wr.en    = advance && (s1_op_r == OP_WRITE) && (32'(s1_led_r) < NUM_LEDS);
  assign wr.base  = POS_W'(32'(s1_led_r) * BYTES_PER_LED);
  assign wr.byte0 = s1_green_r;
  assign wr.byte1 = s1_red_r;
  assign wr.byte2 = s1_blue_r;

  ws_frame_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd     (rd),
    .rd_bit (rd_bit)
  );

  ws_bit_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_en  (advance),
    .op       (s1_op_r),
    .cfg      (cfg_r),
    .rd_bit   (rd_bit),
    .rd       (rd),
    .line_nxt (line_nxt),
    .busy_nxt (busy_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_line_r <= line_nxt;
      out_busy_r <= busy_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_line     = out_line_r;
  assign out_busy_res = out_busy_r;

endmodule

/* rtl/ws_checker.sv */
module ws_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_line,
  input logic out_busy_res,
  input logic pready
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line) && $stable(out_busy_res))
    else $error("result changed while stalled");

  // The line is never driven high while no frame is being sent.
  a_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_line || out_busy_res))
    else $error("line high while idle");

  // With no result waiting, the block must take an item.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

  // An item accepted while the result slot is empty is always followed by a valid result.
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("accepted item produced no result");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind ws2812_bit_serializer_core ws_checker u_ws_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import ws_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 64;
  localparam int RANDOM_TARGET  = 300;
  localparam int PHASE_ITEMS    = 40;
  localparam int LONG_BIT_TICKS = 40;

  typedef struct {
    logic line;
    logic busy;
  } line_state_t;

  // Tracks the frame store and bit timer, and keeps the line levels still owed by the block.
  class ws_line_scoreboard;
    logic [TICK_W-1:0] zero_high, zero_period, one_high, one_period;
    logic [7:0]        frame_bytes [FRAME_BYTES];
    int                byte_pos;
    logic [2:0]        bit_idx;
    logic [TICK_W-1:0] tick_cnt;
    logic              cur_bit;
    bit                sending;
    line_state_t       line_states_q [$];
    int                errors, results, frames;

    function new();
      zero_high   = ZERO_HIGH_RST;
      zero_period = ZERO_PERIOD_RST;
      one_high    = ONE_HIGH_RST;
      one_period  = ONE_PERIOD_RST;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      byte_pos = 0;
      bit_idx  = 3'd7;
      tick_cnt = '0;
      cur_bit  = 1'b0;
      sending  = 1'b0;
      errors   = 0;
      results  = 0;
      frames   = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [TICK_W-1:0] val);
      case (idx)
        REG_ZERO_HIGH:   zero_high = val;
        REG_ZERO_PERIOD: zero_period = val;
        REG_ONE_HIGH:    one_high = val;
        default:         one_period = val;
      endcase
    endfunction

    function logic fetch_bit();
      if (byte_pos >= FRAME_BYTES) return 1'b0;
      return frame_bytes[byte_pos][bit_idx];
    endfunction

    function int high_ticks();
      return cur_bit ? one_high : zero_high;
    endfunction

    function int period_ticks();
      return cur_bit ? one_period : zero_period;
    endfunction

    function void advance_tick();
      int nxt;
      if (!sending) return;
      nxt = tick_cnt + 1;
      if (nxt < period_ticks()) begin
        tick_cnt = TICK_W'(nxt);
        return;
      end
      tick_cnt = '0;
      if (bit_idx == 3'd0) begin
        bit_idx = 3'd7;
        byte_pos++;
      end else begin
        bit_idx--;
      end
      if (byte_pos >= FRAME_BYTES) begin
        sending  = 1'b0;
        byte_pos = 0;
        bit_idx  = 3'd7;
        cur_bit  = 1'b0;
      end else begin
        cur_bit = fetch_bit();
      end
    endfunction

    // Returns whether the item had any effect on the block.
    function bit note_item(logic [1:0] op, logic [2:0] led, logic [7:0] red, green, blue);
      line_state_t ls;
      int          base;
      bit          effective;
      effective = (op == OP_WRITE && led < NUM_LEDS) || (op == OP_START && !sending) ||
                  (op == OP_TICK && sending);
      case (op)
        OP_WRITE: begin
          if (led < NUM_LEDS) begin
            base = led * BYTES_PER_LED;
            frame_bytes[base]     = green;
            frame_bytes[base + 1] = red;
            frame_bytes[base + 2] = blue;
          end
        end
        OP_START: begin
          if (!sending) begin
            sending  = 1'b1;
            byte_pos = 0;
            bit_idx  = 3'd7;
            tick_cnt = '0;
            cur_bit  = fetch_bit();
            frames++;
          end
        end
        OP_TICK: advance_tick();
        default: ;
      endcase
      ls.line = sending && (tick_cnt < high_ticks());
      ls.busy = sending;
      line_states_q.push_back(ls);
      return effective;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic line, logic busy);
      line_state_t ls;
      if (line_states_q.size() == 0) begin
        flag($sformatf("result line=%b busy=%b arrived with nothing outstanding", line, busy));
        return;
      end
      ls = line_states_q.pop_front();
      results++;
      if (line !== ls.line || busy !== ls.busy)
        flag($sformatf("result %0d: line=%b busy=%b, expected line=%b busy=%b",
                       results, line, busy, ls.line, ls.busy));
    endfunction

    function int pending();
      return line_states_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_op;
  logic [2:0]        in_led;
  logic [7:0]        in_red, in_green, in_blue;
  logic              out_valid;
  logic              out_ready;
  logic              out_line;
  logic              out_busy_res;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  ws_line_scoreboard sb;
  bit                hold_req;
  int                holds_seen;
  int                force_burst;
  int                burst_left;
  int                items_sent;
  int                items_effective;
  int                settings_used;
  int                cycle_count;

  ws2812_bit_serializer_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_led      (in_led),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_line    (out_line),
    .out_busy_res(out_busy_res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_line, out_busy_res);
  end

  // Receiver: stretches of steady, mostly ready, sparse or patterned readiness, plus long holds on request.
  initial begin
    int mode;
    int stretch;
    int phase;
    mode = 0;
    stretch = 0;
    phase = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        holds_seen++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 3);
          stretch = $urandom_range(20, 150);
        end
        stretch--;
        phase++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 9) < 7);
          2:       out_ready <= ($urandom_range(0, 9) < 3);
          default: out_ready <= ((phase % 8) < 5);
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles, %0d results outstanding.", cycle_count, sb.pending());
    $display("** ws2812_bit_serializer_core: FAILED **");
    $finish;
  end

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic pace_sender();
    if (force_burst > 0) begin
      force_burst--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause_sender(($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [2:0] led,
                           input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue);
    in_valid <= 1'b1;
    in_op    <= op;
    in_led   <= led;
    in_red   <= red;
    in_green <= green;
    in_blue  <= blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_item(op, led, red, green, blue)) items_effective++;
    items_sent++;
    pace_sender();
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_random();
    int         roll;
    logic [1:0] op;
    roll = $urandom_range(0, 99);
    if (sb.sending)
      op = (roll < 72) ? OP_TICK : (roll < 86) ? OP_WRITE : (roll < 93) ? OP_START : OP_UNUSED;
    else
      op = (roll < 50) ? OP_WRITE : (roll < 75) ? OP_START : (roll < 88) ? OP_TICK : OP_UNUSED;
    send_item(op, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic finish_frame();
    while (sb.sending) send_tick();
  endtask

  task automatic run_frame();
    send_item(OP_START, 3'd0, 8'h00, 8'h00, 8'h00);
    finish_frame();
  endtask

  task automatic fill_frame(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    for (int i = 0; i < NUM_LEDS; i++) send_item(OP_WRITE, 3'(i), red, green, blue);
  endtask

  // Lets every outstanding result drain before the timing registers are touched.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_check(input logic [1:0] idx, input logic [TICK_W-1:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= ADDR_W'(idx) << 2;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[TICK_W-1:0] !== want)
      sb.flag($sformatf("register %0d reads %0d, expected %0d", idx, prdata[TICK_W-1:0], want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [TICK_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cfg_check(idx, val);
  endtask

  task automatic set_timing(input logic [TICK_W-1:0] zero_high, input logic [TICK_W-1:0] zero_period,
                            input logic [TICK_W-1:0] one_high, input logic [TICK_W-1:0] one_period);
    cfg_write(REG_ZERO_HIGH, zero_high);
    cfg_write(REG_ZERO_PERIOD, zero_period);
    cfg_write(REG_ONE_HIGH, one_high);
    cfg_write(REG_ONE_PERIOD, one_period);
    settings_used++;
  endtask

  function automatic logic [TICK_W-1:0] pick_period();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return TICK_W'($urandom_range(0, 1));
    if (roll < 8) return TICK_W'($urandom_range(2, 3));
    return TICK_W'($urandom_range(4, 7));
  endfunction

  function automatic logic [TICK_W-1:0] pick_high(input logic [TICK_W-1:0] period);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll == 2) return period;
    return TICK_W'($urandom_range(1, period + 1));
  endfunction

  initial begin
    logic [TICK_W-1:0] zp, op;
    int                start_mark;
    int                phases;
    sb = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_op    <= OP_WRITE;
    in_led   <= 3'd0;
    in_red   <= 8'h00;
    in_green <= 8'h00;
    in_blue  <= 8'h00;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= 32'h0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_check(REG_ZERO_HIGH, ZERO_HIGH_RST);
    cfg_check(REG_ZERO_PERIOD, ZERO_PERIOD_RST);
    cfg_check(REG_ONE_HIGH, ONE_HIGH_RST);
    cfg_check(REG_ONE_PERIOD, ONE_PERIOD_RST);

    // Zero high time, and bit periods of one and zero ticks. The first frame runs on the
    // store as reset left it, while writes land on bytes still waiting to go out.
    set_timing(12'd0, 12'd1, 12'd1, 12'd0);
    send_item(OP_UNUSED, 3'(NUM_LEDS), 8'hFF, 8'hFF, 8'hFF);
    send_tick();
    send_item(OP_START, 3'd0, 8'h00, 8'h00, 8'h00);
    send_item(OP_START, 3'd0, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_WRITE, 3'(NUM_LEDS - 1), 8'h00, 8'hFF, 8'hFF);
    send_item(OP_WRITE, 3'(NUM_LEDS), 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_UNUSED, 3'd0, 8'h00, 8'h00, 8'h00);
    send_item(OP_WRITE, 3'd0, 8'hFF, 8'h00, 8'h00);
    finish_frame();
    settle();

    // High times beyond and at the period.
    set_timing(12'hFFF, 12'd2, 12'd1, 12'd1);
    fill_frame(8'hFF, 8'h00, 8'hFF);
    send_item(OP_WRITE, 3'(NUM_LEDS - 1), 8'h5A, 8'hA5, 8'h0F);
    run_frame();
    settle();

    // A long zero bit near the top of the timer range, cut short by a timing change
    // in the middle of the frame.
    set_timing(12'd4094, 12'hFFF, 12'hFFF, 12'hFFF);
    fill_frame(8'h0F, 8'h70, 8'h3C);
    send_item(OP_START, 3'd0, 8'h00, 8'h00, 8'h00);
    repeat (LONG_BIT_TICKS) send_tick();
    settle();
    set_timing(12'd0, 12'd1, 12'd1, 12'd1);
    finish_frame();
    settle();

    // Timing changes between phases, also while a frame is going out.
    start_mark = items_effective;
    phases = 0;
    while (items_effective - start_mark < RANDOM_TARGET || phases < 4) begin
      zp = pick_period();
      op = pick_period();
      set_timing(pick_high(zp), zp, pick_high(op), op);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Stop the receiver for a while and keep offering items so the block backs up.
        if (i == 10) begin
          hold_req = 1'b1;
          force_burst = 30;
        end
        send_random();
      end
      settle();
      phases++;
    end

    set_timing(12'd1, 12'd1, 12'd0, 12'd1);
    finish_frame();
    settle();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));
    $display("Ran %0d items (%0d with effect) through %0d frames under %0d timing settings.",
             items_sent, items_effective, sb.frames, settings_used);
    $display("Checked %0d results with %0d receiver holds; %0d mismatches.",
             sb.results, holds_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("** ws2812_bit_serializer_core: PASSED **");
    end else begin
      $display("** ws2812_bit_serializer_core: FAILED **");
    end
    $finish;
  end

endmodule
